// ===== rtl/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: byte masks, lead patterns,
// the decoder state type and the per-byte step result type.
// No dependencies.
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LeftW = 2;

  localparam logic [ByteW-1:0] ContPayloadMask = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Mask       = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask       = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask       = 8'h07;

  // Top bits of a byte compared against these patterns
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  localparam logic [LeftW-1:0] LeftNone  = 2'd0;
  localparam logic [LeftW-1:0] LeftOne   = 2'd1;
  localparam logic [LeftW-1:0] LeftTwo   = 2'd2;
  localparam logic [LeftW-1:0] LeftThree = 2'd3;

  typedef struct packed {
    logic [LeftW-1:0] bytes_left;
    logic [CpW-1:0]   accumulator;
    logic             seq_error;
  } dec_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           ok;
  } dec_result_t;

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// Lenient UTF-8 stream decoder, one byte per cycle while the result side does not stall.
//
// Byte channel: byte_valid / byte_stall / in_byte. A byte is taken on a
// rising edge with byte_valid high and byte_stall low.
// Result channel: cp_valid / cp_stall / code_point / valid_res. A lead byte
// below 0x80 or a stray continuation gives one result; a multi-byte sequence
// gives one result on its last byte; other bytes give none.
// Path: the edge that takes the last byte fills the input register; the
// result register is filled from the step logic once the result side can
// accept, and it drives the outputs.
// Throughput: one byte per cycle while the result side does not stall; the
// only loop is the decoder state register through one step of logic.
// Stall: while cp_stall holds a pending result, the byte in the input
// register waits, and byte_stall rises once that register is occupied.
// Reset clears the valid flags of both registers and the decoder state; no sequence pending.
// Depends on utf8d_pkg and utf8d_step.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [ByteW-1:0] in_byte,
  output logic             cp_valid,
  input  logic             cp_stall,
  output logic [CpW-1:0]   code_point,
  output logic             valid_res
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  dec_state_t       state;
  dec_state_t       state_next;
  dec_result_t      result;
  logic             out_free;
  logic             fire;

  assign out_free   = !cp_valid || !cp_stall;
  assign fire       = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  utf8d_step u_step (
    .state      (state),
    .in_byte    (s1_byte),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (out_free) begin
      cp_valid <= fire && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && result.emit) begin
      code_point <= result.code_point;
      valid_res  <= result.ok;
    end
  end

endmodule

// ===== rtl/utf8d_step.sv =====
// Per-byte decode step: next decoder state and the optional result.
// Depends on utf8d_pkg.
module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t       state,
  input  logic [ByteW-1:0] in_byte,
  output dec_state_t       state_next,
  output dec_result_t      result
);

  logic [CpW-1:0] acc_shift;
  logic           err_new;

  assign acc_shift = {state.accumulator[CpW-7:0], in_byte[5:0]};
  assign err_new   = state.seq_error | (in_byte[7:6] != ContTag);

  always_comb begin
    state_next = state;
    result     = '0;
    if (state.bytes_left == LeftNone) begin
      if (!in_byte[7]) begin
        result.emit       = 1'b1;
        result.ok         = 1'b1;
        result.code_point = {{(CpW-ByteW){1'b0}}, in_byte};
      end else if (in_byte[7:6] == ContTag) begin
        // stray continuation: invalid result for this byte alone
        result.emit = 1'b1;
      end else begin
        state_next.seq_error = 1'b0;
        if (in_byte[7:5] == Lead2Tag) begin
          state_next.accumulator = {{(CpW-ByteW){1'b0}}, in_byte & Lead2Mask};
          state_next.bytes_left  = LeftOne;
        end else if (in_byte[7:4] == Lead3Tag) begin
          state_next.accumulator = {{(CpW-ByteW){1'b0}}, in_byte & Lead3Mask};
          state_next.bytes_left  = LeftTwo;
        end else if (in_byte[7:3] == Lead4Tag) begin
          state_next.accumulator = {{(CpW-ByteW){1'b0}}, in_byte & Lead4Mask};
          state_next.bytes_left  = LeftThree;
        end else begin
          // 0xF8 and above: swallow three more bytes, then fail
          state_next.accumulator = '0;
          state_next.seq_error   = 1'b1;
          state_next.bytes_left  = LeftThree;
        end
      end
    end else begin
      state_next.bytes_left = state.bytes_left - LeftOne;
      if (state.bytes_left == LeftOne) begin
        result.emit            = 1'b1;
        result.ok              = !err_new;
        result.code_point      = err_new ? '0 : acc_shift;
        state_next.accumulator = '0;
        state_next.seq_error   = 1'b0;
      end else begin
        state_next.accumulator = acc_shift;
        state_next.seq_error   = err_new;
      end
    end
  end

endmodule
